/* rtl/core/modular_exponentiation_core_defines.svh */
// Assertion macros shared by the modular exponentiation core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modular exponentiation core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modular exponentiation core: next-cycle check failed");

`endif

/* rtl/core/mec_pkg.sv */
// Package of the modular exponentiation core: constants, operand selects and
// the command and status structs between controller and datapath. No dependencies.
package mec_pkg;

    // Width of the payload and configuration fields on the ports.
    localparam int FIELD_BITS = 32;

    // Default operand width.
    localparam int OPERAND_BITS_DEF = 32;

    // Multiplicand select for the shared modular multiplier.
    typedef enum logic [1:0] {
        A_ONE = 2'd0,
        A_ACC = 2'd1,
        A_POW = 2'd2
    } t_asel;

    // Multiplier select.
    typedef enum logic {
        B_BASE = 1'b0,
        B_POW  = 1'b1
    } t_bsel;

    // Destination of a finished product.
    typedef enum logic {
        D_POW = 1'b0,
        D_ACC = 1'b1
    } t_dest;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;     // capture base and exponent, set the accumulator to one
        logic  mstart;   // start a modular multiplication
        t_asel asel;
        t_bsel bsel;
        t_dest dest;
        logic  step;     // one multiplier bit
        logic  clr_lsb;  // clear exponent bit 0 after its multiply
        logic  shift_e;  // move to the next exponent bit
        logic  fin_ok;   // capture the accumulator as the result
        logic  fin_err;  // capture the zero-modulus result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;
        logic e_zero;
        logic e_lsb;
        logic mul_last;
    } t_status;

endpackage

/* rtl/core/mec_datapath.sv */
// Datapath of the modular exponentiation core: modulus register, operand
// registers and a bit-serial shift-and-add modular multiplier. Uses mec_pkg.
module mec_datapath
    import mec_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [FIELD_BITS-1:0] i_cfg_modulus,
    input  logic [FIELD_BITS-1:0] i_base,
    input  logic [FIELD_BITS-1:0] i_exponent,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [FIELD_BITS-1:0] o_result,
    output logic                  o_error
);

    // Operands never exceed the port fields.
    localparam int DW = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;
    localparam int CW = $clog2(DW);

    logic [DW-1:0]         r_mod;
    logic [DW-1:0]         r_base;
    logic [DW-1:0]         r_e;
    logic [DW-1:0]         r_acc;
    logic [DW-1:0]         r_pow;
    logic [DW-1:0]         r_ma;
    logic [DW-1:0]         r_mb;
    logic [DW-1:0]         r_prod;
    logic [CW-1:0]         r_cnt;
    t_dest                 r_dest;
    logic [FIELD_BITS-1:0] r_res;
    logic                  r_err;

    logic [DW:0]   dbl;
    logic [DW:0]   sum;
    logic [DW-1:0] dmod;
    logic [DW-1:0] addend;
    logic [DW-1:0] n_prod;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    logic          mul_last;

    // One multiplier bit: double modulo m, then add the multiplicand modulo m.
    always_comb begin
        dbl    = {r_prod, 1'b0};
        dmod   = (dbl >= {1'b0, r_mod}) ? DW'(dbl - {1'b0, r_mod}) : DW'(dbl);
        addend = r_mb[DW-1] ? r_ma : '0;
        sum    = {1'b0, dmod} + {1'b0, addend};
        n_prod = (sum >= {1'b0, r_mod}) ? DW'(sum - {1'b0, r_mod}) : DW'(sum);
    end

    // Operand selection for a new multiplication.
    always_comb begin
        case (i_cmd.asel)
            A_ONE:   opa = DW'(1);
            A_ACC:   opa = r_acc;
            A_POW:   opa = r_pow;
            default: opa = DW'(1);
        endcase
        opb = (i_cmd.bsel == B_POW) ? r_pow : r_base;
    end

    assign mul_last = (r_cnt == CW'(DW - 1));

    // Modulus register, written only through the configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_modulus[DW-1:0];
        end
    end

    // Operand, multiplier and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base[DW-1:0];
            r_e    <= i_exponent[DW-1:0];
            r_acc  <= DW'(1);
        end
        if (i_cmd.mstart) begin
            r_ma   <= opa;
            r_mb   <= opb;
            r_prod <= '0;
            r_cnt  <= '0;
            r_dest <= i_cmd.dest;
        end
        if (i_cmd.step) begin
            r_prod <= n_prod;
            r_mb   <= r_mb << 1;
            r_cnt  <= r_cnt + CW'(1);
            if (mul_last) begin
                if (r_dest == D_ACC) begin
                    r_acc <= n_prod;
                end else begin
                    r_pow <= n_prod;
                end
            end
        end
        if (i_cmd.clr_lsb) begin
            r_e[0] <= 1'b0;
        end
        if (i_cmd.shift_e) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.fin_ok) begin
            r_res <= FIELD_BITS'(r_acc);
            r_err <= 1'b0;
        end
        if (i_cmd.fin_err) begin
            r_res <= '0;
            r_err <= 1'b1;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.m_zero   = (r_mod == '0);
        o_status.e_zero   = (r_e == '0);
        o_status.e_lsb    = r_e[0];
        o_status.mul_last = mul_last;
    end

    assign o_result = r_res;
    assign o_error  = r_err;

endmodule

/* rtl/core/mec_controller.sv */
// Controller of the modular exponentiation core: one-hot state machine that
// sequences reduction, multiply and square steps. Uses mec_pkg and the defines header.
`include "modular_exponentiation_core_defines.svh"

module mec_controller
    import mec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_result_valid
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_RED   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MULA  = 7'b0010000,
        S_SQR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.mstart   = 1'b0;
        o_cmd.asel     = A_ONE;
        o_cmd.bsel     = B_BASE;
        o_cmd.dest     = D_POW;
        o_cmd.step     = 1'b0;
        o_cmd.clr_lsb  = 1'b0;
        o_cmd.shift_e  = 1'b0;
        o_cmd.fin_ok   = 1'b0;
        o_cmd.fin_err  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                // A zero modulus ends the job at once; otherwise reduce the base.
                if (i_status.m_zero) begin
                    o_cmd.fin_err = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.mstart = 1'b1;
                    o_cmd.asel   = A_ONE;
                    o_cmd.bsel   = B_BASE;
                    o_cmd.dest   = D_POW;
                    n_state      = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.e_zero) begin
                    o_cmd.fin_ok = 1'b1;
                    n_state      = S_DONE;
                end else if (i_status.e_lsb) begin
                    o_cmd.mstart = 1'b1;
                    o_cmd.asel   = A_ACC;
                    o_cmd.bsel   = B_POW;
                    o_cmd.dest   = D_ACC;
                    n_state      = S_MULA;
                end else begin
                    o_cmd.mstart = 1'b1;
                    o_cmd.asel   = A_POW;
                    o_cmd.bsel   = B_POW;
                    o_cmd.dest   = D_POW;
                    n_state      = S_SQR;
                end
            end
            S_MULA: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.clr_lsb = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.shift_e = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);

    // A new multiplication never starts in the middle of another one.
    `MEC_ASSERT_IMPL(a_start_not_step, i_clk, i_rst_n, o_cmd.mstart, !o_cmd.step)
    // The last multiplier bit always hands control back to the exponent check.
    `MEC_ASSERT_NEXT(a_last_to_check, i_clk, i_rst_n, o_cmd.step && i_status.mul_last,
        r_state == S_CHECK)
    // A result strobe lasts one cycle and frees the block.
    `MEC_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, o_result_valid,
        !o_result_valid && !o_busy)
    // A transfer loads the operands and enters preparation.
    `MEC_ASSERT_NEXT(a_accept_prep, i_clk, i_rst_n, i_start && !o_busy, r_state == S_PREP)

endmodule

/* rtl/core/modular_exponentiation_core.sv */
// With W = min(OPERAND_BITS, 32), n the position of the highest set exponent bit plus
// one and k the number of set exponent bits, the strobe follows a base reduction and
// n + k - 1 modular products of W bits; a zero exponent needs only the reduction and a
// zero-modulus job ends in preparation. One shared multiplier runs one bit a cycle.
// A new start is taken the cycle after the result strobe. Synchronous active-low reset
// clears the controller and sets the modulus register to zero.
module modular_exponentiation_core
    import mec_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [FIELD_BITS-1:0] i_cfg_modulus,
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_BITS-1:0] i_base,
    input  logic [FIELD_BITS-1:0] i_exponent,
    output logic                  o_result_valid,
    output logic [FIELD_BITS-1:0] o_result,
    output logic                  o_error
);

    t_cmd    cmd;
    t_status status;

    // The modulus register takes a transfer only while the core is idle, so a
    // running job never sees its modulus change.
    assign o_cfg_ready = !busy;

    // Sequencer.
    mec_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // Registers and the shared modular multiplier.
    mec_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_result      (o_result),
        .o_error       (o_error)
    );

endmodule
